// ----- hdl/tfe_pkg.sv -----
// Shared types and constants of the telemetry frame encoder.
package tfe_pkg;

  localparam int unsigned NumWords = 9;
  localparam int unsigned QDepth   = 2;

  localparam logic [7:0] SyncHi  = 8'hA5;
  localparam logic [7:0] SyncLo  = 8'h5A;
  localparam logic [7:0] EndByte = 8'hAA;

  typedef enum logic [1:0] {
    KIND_ATT = 2'd0,
    KIND_MOT = 2'd1,
    KIND_MAG = 2'd2
  } kind_e;

  // Record kind that is accepted and dropped.
  localparam logic [1:0] KIND_NONE = 2'd3;

  // One classified record: kind plus words already in wire encoding.
  typedef struct packed {
    kind_e                         kind;
    logic [NumWords-1:0][15:0]     words;
  } entry_t;

endpackage

// ----- hdl/tfe_if.sv -----
// Valid/ready channel interfaces for records in and frame bytes out.
interface tfe_rec_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic signed [15:0] word_0;
  logic signed [15:0] word_1;
  logic signed [15:0] word_2;
  logic signed [15:0] word_3;
  logic signed [15:0] word_4;
  logic signed [15:0] word_5;
  logic signed [15:0] word_6;
  logic signed [15:0] word_7;
  logic signed [15:0] word_8;

  modport source (output valid, op, word_0, word_1, word_2, word_3, word_4,
                  word_5, word_6, word_7, word_8, input ready);
  modport sink   (input valid, op, word_0, word_1, word_2, word_3, word_4,
                  word_5, word_6, word_7, word_8, output ready);
endinterface

interface tfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

// ----- hdl/tfe_front.sv -----
// Front end: accepts records, classifies the kind and encodes the words.
module tfe_front (
  tfe_rec_if.sink        rec,
  input  logic           full_i,
  output logic           push_o,
  output tfe_pkg::entry_t entry_o
);
  import tfe_pkg::*;

  // sign-magnitude; most negative value wraps to zero
  function automatic logic [15:0] enc_sm(input logic [15:0] v);
    logic [15:0] r;
    r = v[15] ? (16'h8000 - v) : v;
    return r;
  endfunction

  logic raw_rate;

  assign rec.ready = !full_i;
  // unused kind is taken and dropped
  assign push_o    = rec.valid && !full_i && (rec.op != KIND_NONE);

  always_comb begin
    raw_rate      = (rec.op != KIND_MOT);
    entry_o.kind  = kind_e'(rec.op);
    entry_o.words[0] = enc_sm(rec.word_0);
    entry_o.words[1] = enc_sm(rec.word_1);
    entry_o.words[2] = enc_sm(rec.word_2);
    entry_o.words[3] = enc_sm(rec.word_3);
    entry_o.words[4] = enc_sm(rec.word_4);
    entry_o.words[5] = enc_sm(rec.word_5);
    entry_o.words[6] = raw_rate ? rec.word_6 : enc_sm(rec.word_6);
    entry_o.words[7] = enc_sm(rec.word_7);
    entry_o.words[8] = enc_sm(rec.word_8);
  end

endmodule

// ----- hdl/tfe_queue.sv -----
// Short queue of classified records between front and back.
module tfe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tfe_pkg::entry_t entry_i,
  input  logic            pop_i,
  output tfe_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import tfe_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  entry_t            mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(QDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- hdl/tfe_back.sv -----
// Back end: byte sequencer, running checksum and output register.
module tfe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tfe_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  tfe_byte_if.source      frame
);
  import tfe_pkg::*;

  entry_t      cur_q, cur_d;
  logic        busy_q, busy_d;
  logic [4:0]  idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        ol_q, ol_d;

  logic [4:0]  nbytes;
  logic [7:0]  len_c, type_c, byte_c;
  logic        last_c, data_c, adv, at_end;
  logic [4:0]  dofs;
  logic [3:0]  widx;
  logic [15:0] wsel;

  function automatic logic [7:0] seed_of(input kind_e k);
    logic [7:0] s;
    unique case (k)
      KIND_ATT: s = 8'hB3;
      KIND_MOT: s = 8'hB8;
      KIND_MAG: s = 8'hB6;
      default:  s = 8'h00;
    endcase
    return s;
  endfunction

  always_comb begin
    unique case (cur_q.kind)
      KIND_MOT: begin nbytes = 5'd24; len_c = 8'd22; type_c = 8'hA2; end
      KIND_MAG: begin nbytes = 5'd20; len_c = 8'd18; type_c = 8'hA4; end
      default:  begin nbytes = 5'd20; len_c = 8'd18; type_c = 8'hA1; end
    endcase
    dofs = idx_q - 5'd4;
    widx = dofs[4:1];
    wsel = (widx < 4'(NumWords)) ? cur_q.words[widx] : 16'h0000;
    last_c = 1'b0;
    data_c = 1'b0;
    priority if (idx_q == 5'd0) begin
      byte_c = SyncHi;
    end else if (idx_q == 5'd1) begin
      byte_c = SyncLo;
    end else if (idx_q == 5'd2) begin
      byte_c = len_c;
    end else if (idx_q == 5'd3) begin
      byte_c = type_c;
    end else if (idx_q == nbytes - 5'd2) begin
      byte_c = sum_q;
    end else if (idx_q == nbytes - 5'd1) begin
      byte_c = EndByte;
      last_c = 1'b1;
    end else begin
      byte_c = dofs[0] ? wsel[7:0] : wsel[15:8];
      data_c = 1'b1;
    end
  end

  // output slot frees when empty or taken this cycle
  assign adv    = !ov_q || frame.ready;
  assign at_end = busy_q && last_c;
  assign pop_o  = adv && (!busy_q || at_end) && !empty_i;

  always_comb begin
    cur_d  = cur_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    sum_d  = sum_q;
    ov_d   = ov_q;
    ob_d   = ob_q;
    ol_d   = ol_q;
    if (adv) begin
      ov_d = busy_q;
      ob_d = byte_c;
      ol_d = last_c;
      if (busy_q) begin
        idx_d = idx_q + 1'b1;
        if (data_c) begin
          sum_d = sum_q + byte_c;
        end
      end
      if (!busy_q || at_end) begin
        busy_d = !empty_i;
      end
    end
    if (pop_o) begin
      cur_d = head_i;
      idx_d = '0;
      sum_d = seed_of(head_i.kind);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    sum_q <= sum_d;
    ob_q  <= ob_d;
    ol_q  <= ol_d;
  end

  assign frame.valid      = ov_q;
  assign frame.frame_byte = ob_q;
  assign frame.last_byte  = ol_q;

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ol_q) |-> (ob_q == EndByte))
    else $error("last word is not the end byte");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < nbytes))
    else $error("byte index past frame end");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (busy_q && idx_q == 5'd0))
    else $error("frame load did not restart sequencer");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

endmodule

// ----- hdl/telemetry_frame_encoder.sv -----
// Top level of the telemetry frame encoder.
//
// Usage:
//   rec_i   : valid/ready channel, one telemetry record per word (op plus
//             nine signed 16-bit values). Kind 3 is accepted and dropped.
//   frame_o : valid/ready channel, one frame byte per word; last_byte marks
//             the closing AA byte of each frame.
// Path: when the encoder is idle, the first byte (A5) of an accepted record
//   goes through the record queue, the sequencer register and output register.
// Throughput: one byte per cycle out of the output register while
//   frame_o.ready is high; a frame is 20 bytes (attitude, magnetometer) or
//   24 bytes (motion), as the byte sequencer in the back end sets. Frames follow
//   each other without gap cycles when the next record is already queued.
// A two-entry record queue sits between the front end and the sequencer, so
//   records keep being accepted while a frame is still streaming out.
// Stall: while frame_o.ready is low the current byte holds, the sequencer
//   waits, and rec_i.ready drops once the queue is full.
// Reset (rst_ni low, async): queue emptied, sequencer idle, frame_o.valid low.
module telemetry_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfe_rec_if.sink     rec_i,
  tfe_byte_if.source  frame_o
);
  import tfe_pkg::*;

  entry_t front_entry;
  entry_t q_head;
  logic   q_push, q_pop, q_empty, q_full;

  // classify and encode
  tfe_front u_front (
    .rec     (rec_i),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (front_entry)
  );

  // decouples acceptance from byte streaming
  tfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // sequencer with checksum and registered output
  tfe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (q_head),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .frame   (frame_o)
  );

endmodule
